FILE: src/mcbe_pkg.sv
// Shared types and constants for the mip chain byte estimator.
`default_nettype none

package mcbe_pkg;

    localparam int IN_DIM_W  = 16;
    localparam int RATIO_W   = 8;
    localparam int TOTAL_W   = 41;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_RATIO,
        ST_DINIT,
        ST_DIVIDE,
        ST_ACCUM,
        ST_STORE
    } mcbe_state_t;

    typedef struct packed {
        logic load;
        logic mul_area;
        logic mul_ratio;
        logic div_init;
        logic div_step;
        logic accum;
        logic out_load;
    } mcbe_cmd_t;

    typedef struct packed {
        logic zero;
        logic div_done;
        logic last_level;
    } mcbe_status_t;

endpackage

`default_nettype wire

FILE: src/mcbe_chan_if.sv
// Handshake interfaces for the texture input channel and the estimate output channel.
`default_nettype none

interface mcbe_in_if;
    import mcbe_pkg::*;

    logic                valid;
    logic                ready;
    logic [IN_DIM_W-1:0] width_pixels;
    logic [IN_DIM_W-1:0] height_pixels;
    logic [RATIO_W-1:0]  bpp_numerator;
    logic [RATIO_W-1:0]  bpp_denominator;
    logic                with_mips;

    modport source (
        output valid, width_pixels, height_pixels, bpp_numerator, bpp_denominator,
               with_mips,
        input  ready
    );

    modport sink (
        input  valid, width_pixels, height_pixels, bpp_numerator, bpp_denominator,
               with_mips,
        output ready
    );
endinterface

interface mcbe_out_if;
    import mcbe_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_bytes;

    modport source (
        output valid, total_bytes,
        input  ready
    );

    modport sink (
        input  valid, total_bytes,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/mip_chain_byte_estimate.sv
// Top level of the mip chain texture byte-size estimator.
//
// One transaction on the texture channel carries a base width and height, a
// bytes-per-pixel ratio as numerator over denominator, and a mipmapped flag.
// One transaction on the estimate channel returns the summed byte count, with
// each mip level rounded up on its own.
// Each level runs through width times height, the ratio multiply, setting up
// rounding, the bit-serial restoring divider over a 2*DIM_BITS + 9 bit
// dividend, and a step to accumulate and halve. A texture without mips has
// one level; a mipmapped one has up to DIM_BITS levels. An empty texture, a
// zero numerator or a zero denominator skips the levels and returns zero.
// A new texture is taken only once the previous one has moved into the output
// register, which holds one result while the receiver stalls; the block then
// waits with its next result until that register is free.
// Reset clears the controller and the output valid flag.
`default_nettype none

module mip_chain_byte_estimate #(
    parameter int DIM_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mcbe_in_if.sink    texture,
    mcbe_out_if.source estimate
);
    import mcbe_pkg::*;

    mcbe_cmd_t    cmd;
    mcbe_status_t status;

    mcbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (texture.valid),
        .in_ready  (texture.ready),
        .out_valid (estimate.valid),
        .out_ready (estimate.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mcbe_dp #(
        .DIM_BITS (DIM_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .width_pixels    (texture.width_pixels),
        .height_pixels   (texture.height_pixels),
        .bpp_numerator   (texture.bpp_numerator),
        .bpp_denominator (texture.bpp_denominator),
        .with_mips       (texture.with_mips),
        .total_bytes     (estimate.total_bytes)
    );

endmodule

`default_nettype wire

FILE: src/mcbe_ctrl.sv
// Controller state machine that sequences the per-level multiply, divide and accumulate.
`default_nettype none

module mcbe_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire mcbe_pkg::mcbe_status_t status,
    output mcbe_pkg::mcbe_cmd_t        cmd
);
    import mcbe_pkg::*;

    mcbe_state_t state_reg;
    mcbe_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        store_fire;
    logic        out_take;

    assign store_fire = (state_reg == ST_STORE) && (!out_valid_reg || out_ready);
    assign out_take   = out_valid_reg && out_ready;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_AREA;
                end
            end
            ST_AREA:
            begin
                state_next = status.zero ? ST_STORE : ST_RATIO;
            end
            ST_RATIO:
            begin
                state_next = ST_DINIT;
            end
            ST_DINIT:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                state_next = status.last_level ? ST_STORE : ST_AREA;
            end
            ST_STORE:
            begin
                if (store_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_AREA:   cmd.mul_area  = 1'b1;
            ST_RATIO:  cmd.mul_ratio = 1'b1;
            ST_DINIT:  cmd.div_init  = 1'b1;
            ST_DIVIDE: cmd.div_step  = 1'b1;
            ST_ACCUM:  cmd.accum     = 1'b1;
            ST_STORE:  cmd.out_load  = store_fire;
            default:   cmd           = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (store_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_div_to_accum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && status.div_done) |=> (state_reg == ST_ACCUM))
        else $error("divider finished but accumulate did not follow");

    a_store_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE && out_valid_reg && !out_ready) |=> (state_reg == ST_STORE))
        else $error("result left the store state while the output was still full");

    a_valid_from_store: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_STORE))
        else $error("output became valid outside the store state");

endmodule

`default_nettype wire

FILE: src/mcbe_dp.sv
// Datapath with the level dimensions, two multipliers, a restoring divider and the byte sum.
`default_nettype none

module mcbe_dp #(
    parameter int DIM_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mcbe_pkg::mcbe_cmd_t             cmd,
    output mcbe_pkg::mcbe_status_t               status,
    input  wire logic [mcbe_pkg::IN_DIM_W-1:0]   width_pixels,
    input  wire logic [mcbe_pkg::IN_DIM_W-1:0]   height_pixels,
    input  wire logic [mcbe_pkg::RATIO_W-1:0]    bpp_numerator,
    input  wire logic [mcbe_pkg::RATIO_W-1:0]    bpp_denominator,
    input  wire logic                            with_mips,
    output logic [mcbe_pkg::TOTAL_W-1:0]         total_bytes
);
    import mcbe_pkg::*;

    localparam int AREA_W = 2 * DIM_BITS;
    localparam int PROD_W = AREA_W + RATIO_W;
    localparam int DVD_W  = PROD_W + 1;
    localparam int CNT_W  = $clog2(DVD_W);

    logic [DIM_BITS-1:0] w_reg;
    logic [DIM_BITS-1:0] h_reg;
    logic [RATIO_W-1:0]  num_reg;
    logic [RATIO_W-1:0]  den_reg;
    logic                mips_reg;
    logic                zero_reg;
    logic [AREA_W-1:0]   area_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [RATIO_W-1:0]  rem_reg;
    logic [DVD_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  out_reg;

    logic [RATIO_W:0]    trial;
    logic                fits;
    logic [RATIO_W-1:0]  trial_diff;
    logic [DIM_BITS-1:0] w_half;
    logic [DIM_BITS-1:0] h_half;

    assign trial      = {rem_reg, quo_reg[DVD_W-1]};
    assign trial_diff = trial[RATIO_W-1:0] - den_reg;
    assign fits       = trial >= {1'b0, den_reg};
    assign w_half     = (w_reg >> 1) | DIM_BITS'(w_reg <= DIM_BITS'(1));
    assign h_half     = (h_reg >> 1) | DIM_BITS'(h_reg <= DIM_BITS'(1));

    assign status.zero       = zero_reg;
    assign status.div_done   = (cnt_reg == CNT_W'(DVD_W - 1));
    assign status.last_level = !mips_reg || (w_reg == DIM_BITS'(1) && h_reg == DIM_BITS'(1));
    assign total_bytes       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            zero_reg <= 1'b0;
            mips_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                zero_reg <= (width_pixels[DIM_BITS-1:0] == '0)
                         || (height_pixels[DIM_BITS-1:0] == '0)
                         || (bpp_numerator == '0) || (bpp_denominator == '0);
                mips_reg <= with_mips;
            end
            if (cmd.div_init)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg     <= width_pixels[DIM_BITS-1:0];
            h_reg     <= height_pixels[DIM_BITS-1:0];
            num_reg   <= bpp_numerator;
            den_reg   <= bpp_denominator;
            total_reg <= '0;
        end
        if (cmd.mul_area)
        begin
            area_reg <= AREA_W'(w_reg) * AREA_W'(h_reg);
        end
        if (cmd.mul_ratio)
        begin
            prod_reg <= PROD_W'(area_reg) * PROD_W'(num_reg);
        end
        if (cmd.div_init)
        begin
            quo_reg <= DVD_W'(prod_reg) + DVD_W'(den_reg) - DVD_W'(1);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? trial_diff : trial[RATIO_W-1:0];
        end
        if (cmd.accum)
        begin
            total_reg <= total_reg + TOTAL_W'(quo_reg);
            w_reg     <= w_half;
            h_reg     <= h_half;
        end
        if (cmd.out_load)
        begin
            out_reg <= total_reg;
        end
    end

    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (total_reg == '0))
        else $error("byte sum not cleared when a transaction was taken");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < den_reg))
        else $error("divider remainder reached the denominator");

    a_dims_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accum && !zero_reg) |=> (w_reg != '0 && h_reg != '0))
        else $error("level dimension dropped to zero");

endmodule

`default_nettype wire
